>>> src/elgc_pkg.sv
// ----------------------------------------------------------------------------
// elgc_pkg
// Shared types and codes for the ElGamal byte cipher core.
// ----------------------------------------------------------------------------
package elgc_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY       = 2'd2;

  // operating modes
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  message_byte;
    logic [63:0] session_exponent;
    logic [63:0] cipher_first;
    logic [63:0] cipher_second;
  } in_word_t;

  typedef struct packed {
    logic [63:0] out_first;
    logic [63:0] out_second;
    logic [7:0]  plain_byte;
    logic        status;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_STEP,
    ST_MUL,
    ST_SQR,
    ST_FIN,
    ST_OUT
  } elgc_state_e;

endpackage

>>> src/elgc_mulmod.sv
// ----------------------------------------------------------------------------
// elgc_mulmod
// Serial modular multiplier: double-and-add over the bits of b, MSB first.
// Operand a must already be below m; b may hold any value.
// ----------------------------------------------------------------------------
module elgc_mulmod #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] m_i,
  output logic         done_o,
  output logic [W-1:0] res_o
);

  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  acc_q, a_q, b_q, m_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, add_q, done_q;

  logic [W:0]   sum, diff;
  logic [W-1:0] red;

  // one modular add per cycle: doubling phase, then conditional add phase
  always_comb begin
    sum  = {1'b0, acc_q} + {1'b0, (add_q ? a_q : acc_q)};
    diff = sum - {1'b0, m_q};
    red  = (sum >= {1'b0, m_q}) ? diff[W-1:0] : sum[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      add_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      m_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        add_q  <= 1'b0;
        cnt_q  <= CW'(W-1);
        acc_q  <= '0;
        a_q    <= a_i;
        b_q    <= b_i;
        m_q    <= m_i;
      end else if (busy_q) begin
        if (!add_q) begin
          acc_q <= red;
          add_q <= 1'b1;
        end else begin
          if (b_q[cnt_q]) begin
            acc_q <= red;
          end
          add_q <= 1'b0;
          if (cnt_q == '0) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

>>> src/elgamal_byte_cipher_core.sv
// ----------------------------------------------------------------------------
// elgamal_byte_cipher_core
// ElGamal encrypt/decrypt of one byte per word over a prime modulus of up to
// MODULUS_BITS bits, built on one shared serial modular multiplier.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake               | Payload
// --------+-----+-------------------------+------------------------------
// in      | in  | in_valid_i / in_ready_o | in_data_i  (in_word_t)
// out     | out | out_valid_o/out_ready_i | out_data_o (out_word_t)
// cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word at a time. A modular multiply (W = MODULUS_BITS) is a start,
// W double/add pairs and a done strobe. An exponentiation is W steps, each
// a step state, a multiply when the exponent bit is set and then a square.
// Encrypt runs two powers and a final multiply; decrypt adds an initial
// reduction of a.
// A range error shows its result the cycle after the word is accepted.
// Reset clears control and config.
// in_ready_o is high only in idle; the result stays registered until taken.
// ----------------------------------------------------------------------------
module elgamal_byte_cipher_core
  import elgc_pkg::*;
#(
  parameter int unsigned MODULUS_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  localparam int unsigned W  = MODULUS_BITS;
  localparam int unsigned CW = $clog2(W);

  // config registers, low W bits only
  logic [W-1:0] p_q, g_q, key_q;

  elgc_state_e   state_q, state_d;
  logic          mode_q, mode_d;
  logic [7:0]    msg_q, msg_d;
  logic [W-1:0]  k_q, k_d, ca_q, ca_d, cb_q, cb_d;
  logic [W-1:0]  acc_q, acc_d, base_q, base_d, exp_q, exp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pass_q, pass_d;
  logic          go_q, go_d;
  out_word_t     out_q, out_d;

  logic          key_bad, enc_bad;
  logic [W-1:0]  op_a, op_b, mul_res;
  logic          mul_done;

  assign key_bad = (key_q < W'(2)) || (key_q >= p_q);
  assign enc_bad = (g_q == '0) || (g_q >= p_q) || key_bad;

  // config writes: the user must issue them only while idle; not enforced here
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q   <= '0;
      g_q   <= '0;
      key_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MODULUS:   p_q   <= cfg_data_i[W-1:0];
        CFG_GENERATOR: g_q   <= cfg_data_i[W-1:0];
        CFG_KEY:       key_q <= cfg_data_i[W-1:0];
        default:       ;
      endcase
    end
  end

  // multiplier operand select; sampled on the cycle go_q is high
  always_comb begin
    unique case (state_q)
      ST_RED:  begin op_a = W'(1);  op_b = ca_q;   end
      ST_MUL:  begin op_a = acc_q;  op_b = base_q; end
      ST_SQR:  begin op_a = base_q; op_b = base_q; end
      ST_FIN:  begin
        op_a = acc_q;
        op_b = (mode_q == MODE_DEC) ? cb_q : W'(msg_q);
      end
      default: begin op_a = acc_q;  op_b = base_q; end
    endcase
  end

  elgc_mulmod #(
    .W (W)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q),
    .a_i     (op_a),
    .b_i     (op_b),
    .m_i     (p_q),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    msg_d   = msg_q;
    k_d     = k_q;
    ca_d    = ca_q;
    cb_d    = cb_q;
    acc_d   = acc_q;
    base_d  = base_q;
    exp_d   = exp_q;
    cnt_d   = cnt_q;
    pass_d  = pass_q;
    out_d   = out_q;
    go_d    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d = in_data_i.mode;
          msg_d  = in_data_i.message_byte;
          k_d    = in_data_i.session_exponent[W-1:0];
          ca_d   = in_data_i.cipher_first[W-1:0];
          cb_d   = in_data_i.cipher_second[W-1:0];
          out_d  = '0;
          if (in_data_i.mode == MODE_DEC) begin
            if (key_bad) begin
              out_d.status = 1'b1;
              state_d      = ST_OUT;
            end else begin
              // reduce a mod p first
              go_d    = 1'b1;
              state_d = ST_RED;
            end
          end else begin
            if (enc_bad) begin
              out_d.status = 1'b1;
              state_d      = ST_OUT;
            end else begin
              acc_d   = W'(1);
              base_d  = g_q;
              exp_d   = in_data_i.session_exponent[W-1:0];
              cnt_d   = CW'(W-1);
              pass_d  = 1'b0;
              state_d = ST_STEP;
            end
          end
        end
      end
      ST_RED: begin
        if (mul_done) begin
          base_d  = mul_res;
          acc_d   = W'(1);
          exp_d   = key_q;
          cnt_d   = CW'(W-1);
          pass_d  = 1'b0;
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        go_d    = 1'b1;
        state_d = exp_q[0] ? ST_MUL : ST_SQR;
      end
      ST_MUL: begin
        if (mul_done) begin
          acc_d   = mul_res;
          go_d    = 1'b1;
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mul_done) begin
          base_d = mul_res;
          exp_d  = exp_q >> 1;
          if (cnt_q != '0) begin
            cnt_d   = cnt_q - 1'b1;
            state_d = ST_STEP;
          end else if (!pass_q) begin
            // first power done, set up the second
            pass_d  = 1'b1;
            acc_d   = W'(1);
            cnt_d   = CW'(W-1);
            state_d = ST_STEP;
            if (mode_q == MODE_ENC) begin
              out_d.out_first = 64'(acc_q);
              base_d          = key_q;
              exp_d           = k_q;
            end else begin
              // Fermat inverse of the shared secret
              base_d = acc_q;
              exp_d  = p_q - W'(2);
            end
          end else begin
            go_d    = 1'b1;
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (mul_done) begin
          if (mode_q == MODE_ENC) begin
            out_d.out_second = 64'(mul_res);
          end else begin
            out_d.plain_byte = mul_res[7:0];
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      go_q    <= 1'b0;
      pass_q  <= 1'b0;
      cnt_q   <= '0;
      mode_q  <= MODE_ENC;
      msg_q   <= '0;
      k_q     <= '0;
      ca_q    <= '0;
      cb_q    <= '0;
      acc_q   <= '0;
      base_q  <= '0;
      exp_q   <= '0;
      out_q   <= '0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      pass_q  <= pass_d;
      cnt_q   <= cnt_d;
      mode_q  <= mode_d;
      msg_q   <= msg_d;
      k_q     <= k_d;
      ca_q    <= ca_d;
      cb_q    <= cb_d;
      acc_q   <= acc_d;
      base_q  <= base_d;
      exp_q   <= exp_d;
      out_q   <= out_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o  = out_q;

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for elgamal_byte_cipher_core. A directed table covers
// reset, the range checks and the operand extremes. Random phases follow under
// new modulus, generator and key settings. Results not given in the table are
// checked against an exact 128-bit model of the modular math.
// ----------------------------------------------------------------------------
module tb_top;
  import elgc_pkg::*;

  localparam logic [63:0] BIG_PRIME   = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam int          STALL_LIMIT = 400000;
  localparam out_word_t   ERR_RESULT  = '{64'd0, 64'd0, 8'd0, 1'b1};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_word_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_word_t            out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [63:0]          cfg_data_i;

  elgamal_byte_cipher_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // bench copy of the register file
  logic [63:0] modulus_q, generator_q, key_q;

  out_word_t pending_results[$];
  int        mismatches;
  int        send_idle_pct, recv_idle_pct;
  int        stall_cycles;

  // directed stimulus table
  typedef struct {
    bit          reconfig;
    logic [63:0] p, g, key;
    in_word_t    word;
    bit          typed;
    out_word_t   result;
  } cipher_row_t;

  cipher_row_t directed_rows[$];

  // ---------------------------------------------------------------------------
  // exact modular math
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [127:0] prod;
    if (m == 64'd0) return 64'd0;
    prod = ({64'd0, x} * {64'd0, y}) % {64'd0, m};
    return prod[63:0];
  endfunction

  // square-and-multiply from the low exponent bit
  function automatic logic [63:0] mod_pow(logic [63:0] base, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    if (m == 64'd0) return 64'd0;
    acc  = 64'd1 % m;
    base = base % m;
    for (int i = 0; i < 64; i++) begin
      if (e[i]) acc = mod_mul(acc, base, m);
      base = mod_mul(base, base, m);
    end
    return acc;
  endfunction

  // expected result of one word under the current register copy
  function automatic out_word_t cipher_result(in_word_t w);
    out_word_t   r;
    logic [63:0] shared, inverse, recovered;
    logic        key_bad;
    r       = '0;
    key_bad = (key_q < 64'd2) || (key_q >= modulus_q);
    if (w.mode == MODE_ENC) begin
      if (generator_q == 64'd0 || generator_q >= modulus_q || key_bad) begin
        r.status = 1'b1;
      end else begin
        r.out_first  = mod_pow(generator_q, w.session_exponent, modulus_q);
        r.out_second = mod_mul({56'd0, w.message_byte},
                               mod_pow(key_q, w.session_exponent, modulus_q), modulus_q);
      end
    end else begin
      if (key_bad) begin
        r.status = 1'b1;
      end else begin
        // b / a^x via Fermat inverse; a zero shared value yields zero
        shared       = mod_pow(w.cipher_first, key_q, modulus_q);
        inverse      = mod_pow(shared, modulus_q - 64'd2, modulus_q);
        recovered    = mod_mul(w.cipher_second, inverse, modulus_q);
        r.plain_byte = recovered[7:0];
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic cipher_row_t make_row(bit reconfig, logic [63:0] p, logic [63:0] g,
                                           logic [63:0] key, in_word_t word, bit typed,
                                           out_word_t result);
    cipher_row_t r;
    r.reconfig = reconfig;
    r.p        = p;
    r.g        = g;
    r.key      = key;
    r.word     = word;
    r.typed    = typed;
    r.result   = result;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  // valid is lowered only before an idle gap or a drain, never just before
  // being raised again in the same step
  task automatic send_word(in_word_t w, bit typed, out_word_t typed_result);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(typed ? typed_result : cipher_result(w));
  endtask

  // hold the input until every word in flight has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic load_registers(logic [63:0] p, logic [63:0] g, logic [63:0] key);
    logic [63:0] vals[3];
    logic [CFG_IDX_W-1:0] idx[3];
    vals = '{p, g, key};
    idx  = '{CFG_MODULUS, CFG_GENERATOR, CFG_KEY};
    drain_results();
    repeat (4) @(posedge clk_i);
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[i])
        CFG_MODULUS:   modulus_q   = vals[i];
        CFG_GENERATOR: generator_q = vals[i];
        default:       key_q       = vals[i];
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // output side: random back-pressure and the compare
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", out_data_o);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.out_first  !== want.out_first  ||
            out_data_o.out_second !== want.out_second ||
            out_data_o.plain_byte !== want.plain_byte ||
            out_data_o.status     !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, out_data_o);
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL elgamal_byte_cipher_core");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [63:0] primes[5];
    logic [63:0] p, g, key, k, a, b;
    logic [7:0]  m;
    int          pick;
    in_word_t    w;

    primes = '{BIG_PRIME, 64'd3, 64'd4294967291, 64'd251, 64'd65521};

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_MODULUS;
    cfg_data_i    = '0;
    modulus_q     = '0;
    generator_q   = '0;
    key_q         = '0;
    mismatches    = 0;
    stall_cycles  = 0;
    send_idle_pct = 34;
    recv_idle_pct = 58;

    // after reset p is 0, so both modes report a range error
    directed_rows.push_back(make_row(0, 0, 0, 0,
      '{MODE_ENC, 8'hFF, '1, 64'd0, 64'd0}, 1, ERR_RESULT));
    directed_rows.push_back(make_row(0, 0, 0, 0,
      '{MODE_DEC, 8'h00, 64'd0, '1, '1}, 1, ERR_RESULT));
    // key below 2
    directed_rows.push_back(make_row(1, BIG_PRIME, 5, 1,
      '{MODE_ENC, 8'h41, 64'd9, 64'd0, 64'd0}, 1, ERR_RESULT));
    directed_rows.push_back(make_row(0, 0, 0, 0,
      '{MODE_DEC, 8'h00, 64'd0, 64'd7, 64'd9}, 1, ERR_RESULT));
    // generator zero: encrypt fails, decrypt does not care about g
    directed_rows.push_back(make_row(1, BIG_PRIME, 0, 7,
      '{MODE_ENC, 8'h41, 64'd9, 64'd0, 64'd0}, 1, ERR_RESULT));
    directed_rows.push_back(make_row(0, 0, 0, 0,
      '{MODE_DEC, 8'h00, 64'd0, 64'd12345, 64'd678}, 0, '0));
    // generator equal to p
    directed_rows.push_back(make_row(1, BIG_PRIME, BIG_PRIME, 7,
      '{MODE_ENC, 8'h41, 64'd9, 64'd0, 64'd0}, 1, ERR_RESULT));
    // key equal to p
    directed_rows.push_back(make_row(1, BIG_PRIME, 3, BIG_PRIME,
      '{MODE_ENC, 8'h41, 64'd9, 64'd0, 64'd0}, 1, ERR_RESULT));
    directed_rows.push_back(make_row(0, 0, 0, 0,
      '{MODE_DEC, 8'h00, 64'd0, 64'd5, 64'd5}, 1, ERR_RESULT));
    // largest legal g and key; k = 0 gives a = 1 and b = m
    directed_rows.push_back(make_row(1, BIG_PRIME, BIG_PRIME - 1, BIG_PRIME - 1,
      '{MODE_ENC, 8'h00, 64'd0, 64'd0, 64'd0}, 1, '{64'd1, 64'd0, 8'd0, 1'b0}));
    directed_rows.push_back(make_row(0, 0, 0, 0,
      '{MODE_ENC, 8'hFF, '1, '1, '1}, 0, '0));
    // zero shared value recovers zero
    directed_rows.push_back(make_row(0, 0, 0, 0,
      '{MODE_DEC, 8'hFF, '1, 64'd0, '1}, 1, '0));
    directed_rows.push_back(make_row(0, 0, 0, 0,
      '{MODE_DEC, 8'h00, 64'd0, '1, '1}, 0, '0));
    // a equal to p reduces to zero
    directed_rows.push_back(make_row(0, 0, 0, 0,
      '{MODE_DEC, 8'h00, 64'd0, BIG_PRIME, 64'd123}, 1, '0));
    // smallest usable modulus
    directed_rows.push_back(make_row(1, 3, 2, 2,
      '{MODE_ENC, 8'hFF, 64'd5, 64'd0, 64'd0}, 0, '0));
    directed_rows.push_back(make_row(0, 0, 0, 0,
      '{MODE_DEC, 8'h00, 64'd0, 64'd2, 64'd1}, 0, '0));
    // message byte above p gets reduced
    directed_rows.push_back(make_row(1, 251, 6, 100,
      '{MODE_ENC, 8'hFF, 64'hAAAA_5555_F0F0_0F0F, 64'd0, 64'd0}, 0, '0));
    directed_rows.push_back(make_row(0, 0, 0, 0,
      '{MODE_DEC, 8'hFF, '1, '1, 64'h5555_AAAA_0F0F_F0F0}, 0, '0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].reconfig)
        load_registers(directed_rows[i].p, directed_rows[i].g, directed_rows[i].key);
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);
    end

    // random phases, each under fresh register values
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 58;
        recv_idle_pct = 34;
      end else if (ph == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      p = primes[$urandom_range(4)];
      if (ph == 9) p = BIG_PRIME;
      g   = 64'd1 + rand64() % (p - 64'd1);
      key = 64'd2 + rand64() % (p - 64'd2);
      pick = $urandom_range(9);
      if (pick == 0) g = (ph[0]) ? 64'd0 : p + rand64() % (~p + 64'd1);
      if (pick == 1) key = (ph[0]) ? 64'd1 : p + rand64() % (~p + 64'd1);
      load_registers(p, g, key);

      for (int n = 0; n < 10; n++) begin
        if (ph == 5 && n == 5) drain_results();
        m    = $urandom_range(255);
        k    = rand64();
        pick = $urandom_range(99);
        if (pick < 45) begin
          w = '{MODE_ENC, m, k, rand64(), rand64()};
        end else if (pick < 85) begin
          // well-formed cipher pair that should give m mod p back
          a = mod_pow(generator_q, k, modulus_q);
          b = mod_mul({56'd0, m}, mod_pow(a, key_q, modulus_q), modulus_q);
          w = '{MODE_DEC, m, k, a, b};
        end else begin
          w = '{MODE_DEC, m, k, rand64(), rand64()};
        end
        send_word(w, 0, '0);
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS elgamal_byte_cipher_core");
    end else begin
      $display("FAIL elgamal_byte_cipher_core");
    end
    $finish;
  end

endmodule

>>> sim.f
src/elgc_pkg.sv
src/elgc_mulmod.sv
src/elgamal_byte_cipher_core.sv
tb/tb_top.sv
